>>> sv/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> sv/evd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package evd_pkg;

   localparam int FLOOR_COUNT = 4;
   localparam int FLOOR_W = $clog2(FLOOR_COUNT);

   localparam logic REQ_PRESS = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [1:0] BTN_HALL_UP   = 2'd0;
   localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
   localparam logic [1:0] BTN_CAB       = 2'd2;

   localparam logic [1:0] MOT_UP   = 2'd1;
   localparam logic [1:0] MOT_DOWN = 2'd2;

   localparam logic signed [2:0] NO_TARGET = -3'sd1;

   typedef struct packed {
      logic       req_type;
      logic [1:0] floor;
      logic [1:0] button;
      logic [1:0] motion_dir;
      logic [1:0] last_floor;
   } evd_req_type;

   typedef struct packed {
      logic signed [2:0]      next_floor;
      logic                   prefer_up;
      logic [FLOOR_COUNT-1:0] up_pending;
      logic [FLOOR_COUNT-1:0] down_pending;
   } evd_rsp_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_RESP
   } evd_state_type;

   typedef struct packed {
      logic load;
   } evd_cmd_type;

   typedef struct packed {
      logic               found;
      logic [FLOOR_W-1:0] idx;
   } evd_scan_type;

   function automatic evd_scan_type find_lowest(input logic [FLOOR_COUNT-1:0] m);
      evd_scan_type r;
      r = '0;
      for (int f = FLOOR_COUNT - 1; f >= 0; f--) begin
         if (m[f]) begin
            r.found = 1'b1;
            r.idx   = FLOOR_W'(f);
         end
      end
      return r;
   endfunction

   function automatic evd_scan_type find_highest(input logic [FLOOR_COUNT-1:0] m);
      evd_scan_type r;
      r = '0;
      for (int f = 0; f < FLOOR_COUNT; f++) begin
         if (m[f]) begin
            r.found = 1'b1;
            r.idx   = FLOOR_W'(f);
         end
      end
      return r;
   endfunction

   function automatic logic [FLOOR_COUNT-1:0] above_mask(input logic [FLOOR_W-1:0] ref_fl);
      logic [FLOOR_COUNT-1:0] m;
      for (int f = 0; f < FLOOR_COUNT; f++) begin
         m[f] = (f > int'(ref_fl));
      end
      return m;
   endfunction

   function automatic logic [FLOOR_COUNT-1:0] below_mask(input logic [FLOOR_W-1:0] ref_fl);
      logic [FLOOR_COUNT-1:0] m;
      for (int f = 0; f < FLOOR_COUNT; f++) begin
         m[f] = (f < int'(ref_fl));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> sv/evd_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface evd_req_if;
   import evd_pkg::*;
   logic        valid;
   logic        ready;
   evd_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface evd_rsp_if;
   import evd_pkg::*;
   logic        valid;
   logic        ready;
   evd_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/evd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module evd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output evd_pkg::evd_cmd_type    cmd
);
   import evd_pkg::*;

   evd_state_type state_ff;
   evd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTRL_RESP;
            end
         end
         CTRL_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               // a new request may take the slot as the old response leaves
               cmd.load = req_valid;
               state_in = req_valid ? CTRL_RESP : CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/evd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module evd_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire evd_pkg::evd_cmd_type cmd,
   input  wire evd_pkg::evd_req_type req,
   output evd_pkg::evd_rsp_type      rsp
);
   import evd_pkg::*;

   logic [FLOOR_COUNT-1:0] up_ff, up_in;
   logic [FLOOR_COUNT-1:0] down_ff, down_in;
   logic                   pref_ff, pref_in;
   logic signed [2:0]      target_ff, target_in;

   logic [FLOOR_COUNT-1:0] bit_sel;
   logic [FLOOR_W-1:0]     ref_fl;
   evd_scan_type           s_up_ahead, s_down_all, s_down_below, s_up_all;

   always_comb begin
      bit_sel = '0;
      bit_sel[req.floor] = 1'b1;
      up_in   = up_ff;
      down_in = down_ff;
      if (req.req_type == REQ_CLEAR) begin
         up_in   = up_ff & ~bit_sel;
         down_in = down_ff & ~bit_sel;
         ref_fl  = req.floor;
      end else begin
         ref_fl = req.last_floor;
         unique case (req.button)
            BTN_HALL_UP:   up_in = up_ff | bit_sel;
            BTN_HALL_DOWN: down_in = down_ff | bit_sel;
            BTN_CAB: begin
               priority if (req.floor > req.last_floor) begin
                  up_in = up_ff | bit_sel;
               end else if (req.floor < req.last_floor) begin
                  down_in = down_ff | bit_sel;
               end else if (req.motion_dir == MOT_DOWN) begin
                  up_in = up_ff | bit_sel;
               end else if (req.motion_dir == MOT_UP) begin
                  down_in = down_ff | bit_sel;
               end else begin
                  up_in   = up_ff | bit_sel;
                  down_in = down_ff | bit_sel;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // target rescan over the updated order bits
   always_comb begin
      s_up_ahead   = find_lowest(up_in & above_mask(ref_fl));
      s_down_all   = find_highest(down_in);
      s_down_below = find_highest(down_in & below_mask(ref_fl));
      s_up_all     = find_lowest(up_in);
      pref_in      = 1'b1;
      target_in    = NO_TARGET;
      priority if (pref_ff && s_up_ahead.found) begin
         target_in = {1'b0, s_up_ahead.idx};
      end else if (pref_ff && s_down_all.found) begin
         pref_in   = 1'b0;
         target_in = {1'b0, s_down_all.idx};
      end else if (!pref_ff && s_down_below.found) begin
         pref_in   = 1'b0;
         target_in = {1'b0, s_down_below.idx};
      end else if (s_up_all.found) begin
         target_in = {1'b0, s_up_all.idx};
      end else begin
         target_in = NO_TARGET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= '0;
         down_ff <= '0;
         pref_ff <= 1'b1;
      end else if (cmd.load) begin
         up_ff   <= up_in;
         down_ff <= down_in;
         pref_ff <= pref_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= NO_TARGET;
      end else if (cmd.load) begin
         target_ff <= target_in;
      end
   end

   assign rsp.next_floor   = target_ff;
   assign rsp.prefer_up    = pref_ff;
   assign rsp.up_pending   = up_ff;
   assign rsp.down_pending = down_ff;

endmodule

`default_nettype wire

>>> sv/elevator_order_dispatch.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Elevator order dispatcher for four floors. Each request is a button press or a floor
// clear; it updates the up and down order bits and rescans for the next target floor,
// returning one response with the target (-1 when nothing is pending), the preferred
// direction and both order masks. A request is registered in the cycle it is taken and
// its response is offered from the next cycle on; a new request is taken in the same
// cycle the previous response is taken, so with the response side always ready the block
// handles one request per cycle. The order update and the priority scan sit in
// combinational logic in front of the result registers.
module elevator_order_dispatch (
   input wire logic clock,
   input wire logic reset,
   evd_req_if.sink  req_chan,
   evd_rsp_if.source rsp_chan
);
   import evd_pkg::*;

   evd_cmd_type cmd;

   evd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   evd_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_chan.payload),
      .rsp   (rsp_chan.payload)
   );

   `ASSERT_IMPLY(a_resp_follows_req, clock, reset, (req_chan.valid && req_chan.ready) |=> rsp_chan.valid)
   `ASSERT_NEVER(a_idle_prefers_up, clock, reset, rsp_chan.valid && (rsp_chan.payload.next_floor == NO_TARGET) && !rsp_chan.payload.prefer_up)
   `ASSERT_IMPLY(a_target_pending, clock, reset, (rsp_chan.valid && (rsp_chan.payload.next_floor != NO_TARGET)) |-> (rsp_chan.payload.prefer_up ? rsp_chan.payload.up_pending[rsp_chan.payload.next_floor[1:0]] : rsp_chan.payload.down_pending[rsp_chan.payload.next_floor[1:0]]))

endmodule

`default_nettype wire

>>> dv/tb_elevator_order_dispatch.sv
`timescale 1ns / 1ps

module tb_elevator_order_dispatch;
   import evd_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 200;
   localparam logic [1:0] MOT_STOP   = 2'd0;
   localparam logic [1:0] MOT_SPARE  = 2'd3;
   localparam logic [1:0] BTN_SPARE  = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   evd_req_if req_chan();
   evd_rsp_if rsp_chan();

   elevator_order_dispatch dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // order book as the block should hold it
   logic [FLOOR_COUNT-1:0] up_calls = '0;
   logic [FLOOR_COUNT-1:0] down_calls = '0;
   logic heading_up = 1'b1;
   logic signed [2:0] target_view = NO_TARGET;

   evd_rsp_type expected_dispatch[$];
   int mismatch_count = 0;
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int hold_remaining = 0;
   int car_floor = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 250_000);
      $display("tb_elevator_order_dispatch: errors");
      $finish;
   end

   function automatic int lowest_call_from(input logic [FLOOR_COUNT-1:0] m, input int start);
      int f;
      if (start < 0) start = 0;
      for (f = start; f < FLOOR_COUNT; f++) begin
         if (m[f]) return f;
      end
      return -1;
   endfunction

   function automatic int highest_call_from(input logic [FLOOR_COUNT-1:0] m, input int start);
      int f;
      if (start > FLOOR_COUNT - 1) start = FLOOR_COUNT - 1;
      for (f = start; f >= 0; f--) begin
         if (m[f]) return f;
      end
      return -1;
   endfunction

   function automatic int pick_target(input int ref_fl);
      int t;
      if (heading_up) begin
         t = lowest_call_from(up_calls, ref_fl + 1);
         if (t >= 0) return t;
         heading_up = 1'b0;
         t = highest_call_from(down_calls, FLOOR_COUNT - 1);
         if (t >= 0) return t;
      end
      t = highest_call_from(down_calls, ref_fl - 1);
      if (t >= 0) return t;
      heading_up = 1'b1;
      return lowest_call_from(up_calls, 0);
   endfunction

   function automatic evd_rsp_type dispatch_event(input evd_req_type ev);
      logic [FLOOR_COUNT-1:0] floor_bit;
      evd_rsp_type r;
      int ref_fl;
      floor_bit = '0;
      floor_bit[ev.floor] = 1'b1;
      if (ev.req_type == REQ_CLEAR) begin
         up_calls   &= ~floor_bit;
         down_calls &= ~floor_bit;
         ref_fl = ev.floor;
      end else begin
         case (ev.button)
            BTN_HALL_UP: begin
               up_calls |= floor_bit;
            end
            BTN_HALL_DOWN: begin
               down_calls |= floor_bit;
            end
            BTN_CAB: begin
               if (ev.floor > ev.last_floor) begin
                  up_calls |= floor_bit;
               end else if (ev.floor < ev.last_floor) begin
                  down_calls |= floor_bit;
               end else if (ev.motion_dir == MOT_DOWN) begin
                  up_calls |= floor_bit;
               end else if (ev.motion_dir == MOT_UP) begin
                  down_calls |= floor_bit;
               end else begin
                  up_calls   |= floor_bit;
                  down_calls |= floor_bit;
               end
            end
            default: begin
            end
         endcase
         ref_fl = ev.last_floor;
      end
      target_view    = 3'(pick_target(ref_fl));
      r.next_floor   = target_view;
      r.prefer_up    = heading_up;
      r.up_pending   = up_calls;
      r.down_pending = down_calls;
      return r;
   endfunction

   function automatic evd_req_type make_event(input logic rt, input logic [1:0] fl,
                                             input logic [1:0] bt, input logic [1:0] md,
                                             input logic [1:0] lf);
      evd_req_type ev;
      ev.req_type   = rt;
      ev.floor      = fl;
      ev.button     = bt;
      ev.motion_dir = md;
      ev.last_floor = lf;
      return ev;
   endfunction

   task automatic send_event(input evd_req_type ev);
      int gap;
      gap = gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= ev;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      expected_dispatch.push_back(dispatch_event(ev));
   endtask

   task automatic press(input logic [1:0] fl, input logic [1:0] bt, input logic [1:0] md,
                        input logic [1:0] lf);
      send_event(make_event(REQ_PRESS, fl, bt, md, lf));
   endtask

   // fields other than the floor are don't-care on a clear
   task automatic clear_floor(input logic [1:0] fl);
      send_event(make_event(REQ_CLEAR, fl, 2'($urandom), 2'($urandom), 2'($urandom)));
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_dispatch.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
   endtask

   // response side: random stalls plus an occasional long hold
   initial begin : response_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 16) : 0;
         if (stall > 0 || hold_remaining > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_remaining > 0) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      if (hold_remaining > 0) hold_remaining <= hold_remaining - 1;
   end

   always @(posedge clock) begin : check_dispatch
      evd_rsp_type want;
      evd_rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_dispatch.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("response with no request pending: %p", got);
         end else begin
            want = expected_dispatch.pop_front();
            if (got.next_floor !== want.next_floor)
               report_mismatch("next_floor", want.next_floor, got.next_floor);
            if (got.prefer_up !== want.prefer_up)
               report_mismatch("prefer_up", want.prefer_up, got.prefer_up);
            if (got.up_pending !== want.up_pending)
               report_mismatch("up_pending", want.up_pending, got.up_pending);
            if (got.down_pending !== want.down_pending)
               report_mismatch("down_pending", want.down_pending, got.down_pending);
         end
      end
   end

   task automatic test_hall_buttons();
      press(2'd0, BTN_HALL_UP, MOT_STOP, 2'd0);
      press(2'd3, BTN_HALL_DOWN, MOT_STOP, 2'd0);
      press(2'd2, BTN_HALL_UP, MOT_UP, 2'd3);
      press(2'd1, BTN_HALL_DOWN, MOT_DOWN, 2'd3);
      clear_floor(2'd3);
      clear_floor(2'd0);
      clear_floor(2'd2);
      clear_floor(2'd1);
      drain();
   endtask

   task automatic test_cab_routing();
      press(2'd3, BTN_CAB, MOT_STOP, 2'd1);
      press(2'd0, BTN_CAB, MOT_STOP, 2'd2);
      press(2'd2, BTN_CAB, MOT_UP, 2'd2);
      press(2'd2, BTN_CAB, MOT_DOWN, 2'd2);
      press(2'd1, BTN_CAB, MOT_STOP, 2'd1);
      press(2'd1, BTN_CAB, MOT_SPARE, 2'd1);
      clear_floor(2'd0);
      clear_floor(2'd1);
      clear_floor(2'd2);
      clear_floor(2'd3);
      drain();
   endtask

   task automatic test_unused_codes();
      press(2'd2, BTN_SPARE, MOT_SPARE, 2'd0);
      send_event(make_event(REQ_CLEAR, 2'd3, BTN_SPARE, MOT_SPARE, 2'd3));
      drain();
   endtask

   task automatic next_event();
      int tgt;
      logic [1:0] md;
      tgt = target_view;
      if ($urandom_range(0, 9) < 2) begin
         send_event(make_event(1'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                               2'($urandom)));
      end else if (tgt >= 0 && $urandom_range(0, 2) == 0) begin
         car_floor = tgt;
         clear_floor(2'(car_floor));
      end else begin
         if (tgt >= 0 && tgt != car_floor && $urandom_range(0, 2) == 0)
            car_floor += (tgt > car_floor) ? 1 : -1;
         if (tgt < 0 || tgt == car_floor) md = MOT_STOP;
         else if (tgt > car_floor) md = MOT_UP;
         else md = MOT_DOWN;
         press(2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)), md, 2'(car_floor));
      end
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_remaining = HOLD_CYCLES;
      repeat (30) next_event();
      gaps_on = 1'b1;
      drain();
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < 850; n++) begin
         if (n % 50 == 0) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
         end
         next_event();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      drain();
   endtask

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_hall_buttons();
      test_cab_routing();
      test_unused_codes();
      test_backpressure();
      test_random_traffic();
      repeat (10) @(posedge clock);
      if (expected_dispatch.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("tb_elevator_order_dispatch: clean");
      end else begin
         $display("tb_elevator_order_dispatch: errors");
      end
      $finish;
   end

endmodule
